/* sv/aaf_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aaf_pkg - shared types and codes of the accumulator ALU
// Operation codes, flag bit positions and the item and state records.
// ----------------------------------------------------------------------------
package aaf_pkg;

	// operation codes
	localparam logic [3:0] FUNC_ADD  = 4'd0;
	localparam logic [3:0] FUNC_ADC  = 4'd1;
	localparam logic [3:0] FUNC_SUB  = 4'd2;
	localparam logic [3:0] FUNC_SBC  = 4'd3;
	localparam logic [3:0] FUNC_CP   = 4'd4;
	localparam logic [3:0] FUNC_AND  = 4'd5;
	localparam logic [3:0] FUNC_OR   = 4'd6;
	localparam logic [3:0] FUNC_XOR  = 4'd7;
	localparam logic [3:0] FUNC_INC  = 4'd8;
	localparam logic [3:0] FUNC_DEC  = 4'd9;
	localparam logic [3:0] FUNC_RL   = 4'd10;
	localparam logic [3:0] FUNC_RLC  = 4'd11;
	localparam logic [3:0] FUNC_BIT  = 4'd12;
	localparam logic [3:0] FUNC_LDA  = 4'd13;

	// flag bit positions
	localparam int unsigned FLAG_Z = 3;
	localparam int unsigned FLAG_N = 2;
	localparam int unsigned FLAG_H = 1;
	localparam int unsigned FLAG_C = 0;

	typedef struct packed {
		logic [3:0] func;
		logic [7:0] operand;
		logic       to_accumulator;
		logic [2:0] bit_pos;
	} aaf_item_t;

	typedef struct packed {
		logic [7:0] acc;
		logic [3:0] flags;
	} aaf_state_t;

endpackage

/* sv/aaf_in_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aaf_in_if - operation channel
// Valid/ready channel that carries one ALU operation per transfer.
// ----------------------------------------------------------------------------
interface aaf_in_if;
	logic       valid;
	logic       ready;
	logic [3:0] func;
	logic [7:0] operand;
	logic       to_accumulator;
	logic [2:0] bit_pos;

	modport source (output valid, output func, output operand, output to_accumulator,
		output bit_pos, input ready);
	modport sink (input valid, input func, input operand, input to_accumulator,
		input bit_pos, output ready);
endinterface

/* sv/aaf_out_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aaf_out_if - response channel
// Valid/ready channel that carries one result byte and its flags per transfer.
// ----------------------------------------------------------------------------
interface aaf_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] result;
	logic [3:0] flags;

	modport source (output valid, output result, output flags, input ready);
	modport sink (input valid, input result, input flags, output ready);
endinterface

/* sv/aaf_alu.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aaf_alu - accumulator ALU datapath
// Combinational execute of one operation against the current accumulator
// and flags; yields the result byte and the next state.
// ----------------------------------------------------------------------------
module aaf_alu (
	input  aaf_pkg::aaf_item_t  item,
	input  aaf_pkg::aaf_state_t cur,
	output logic [7:0]          result,
	output aaf_pkg::aaf_state_t nxt
);
	import aaf_pkg::*;

	logic       cin;
	logic [7:0] a;
	logic [7:0] v;
	logic [8:0] sum;
	logic [8:0] sub;
	logic [7:0] diff;
	logic [7:0] t;
	logic       low;

	assign a   = cur.acc;
	assign cin = cur.flags[FLAG_C];
	assign v   = item.to_accumulator ? a : item.operand;

	always_comb begin
		sum  = {1'b0, a} + {1'b0, item.operand}
			+ {8'd0, (item.func == FUNC_ADC) & cin};
		sub  = {1'b0, item.operand} + {8'd0, (item.func == FUNC_SBC) & cin};
		diff = a - sub[7:0];
		low  = (item.func == FUNC_RL) ? cin : v[7];
		t    = 8'd0;
		nxt    = cur;
		result = cur.acc;
		case (item.func)
			FUNC_ADD, FUNC_ADC: begin
				nxt.acc   = sum[7:0];
				nxt.flags = {sum[7:0] == 8'd0, 1'b0, 1'b0, sum[8]};
				result    = sum[7:0];
			end
			FUNC_SUB, FUNC_SBC, FUNC_CP: begin
				nxt.flags = {diff == 8'd0, 1'b1, 1'b0, sub > {1'b0, a}};
				if (item.func != FUNC_CP) begin
					nxt.acc = diff;
					result  = diff;
				end
			end
			FUNC_AND, FUNC_OR, FUNC_XOR: begin
				case (item.func)
					FUNC_AND: t = a & item.operand;
					FUNC_OR:  t = a | item.operand;
					default:  t = a ^ item.operand;
				endcase
				nxt.acc   = t;
				nxt.flags = {t == 8'd0, 3'b000};
				result    = t;
			end
			FUNC_INC, FUNC_DEC: begin
				t         = (item.func == FUNC_INC) ? v + 8'd1 : v - 8'd1;
				nxt.flags = {t == 8'd0, 3'b000};
				if (item.to_accumulator) nxt.acc = t;
				result    = t;
			end
			FUNC_RL, FUNC_RLC: begin
				t         = {v[6:0], low};
				nxt.flags = {t == 8'd0, 2'b00, v[7]};
				if (item.to_accumulator) nxt.acc = t;
				result    = t;
			end
			FUNC_BIT: begin
				// zero flag marks a clear tested bit
				nxt.flags = {~item.operand[item.bit_pos], 3'b000};
			end
			FUNC_LDA: begin
				nxt.acc = item.operand;
				result  = item.operand;
			end
			default: begin
				// unused codes leave everything as it is
			end
		endcase
	end

endmodule

/* sv/accumulator_alu_with_flags.sv */
`timescale 1ns / 1ps
// An accepted operation passes through the input stage and then the result
// register before its response is valid. Throughput: one operation per cycle;
// both stages hold while the response side stalls with a full result
// register.
// Reset (arst_n low, asynchronous): accumulator and flags clear to zero and
// both stages empty.
// ----------------------------------------------------------------------------
// accumulator_alu_with_flags - eight-bit accumulator ALU with Z, N, C flags
// An input stage holds one operation; on advance the datapath executes it
// against the accumulator and flags, which update in the same edge as the
// result register.
// ----------------------------------------------------------------------------
module accumulator_alu_with_flags (
	input  logic       clk,
	input  logic       arst_n,
	aaf_in_if.sink     operation,
	aaf_out_if.source  response
);
	import aaf_pkg::*;

	// input stage
	logic       valid_s1;
	aaf_item_t  item_s1;

	// architectural state
	aaf_state_t state_q;

	// result register
	logic       out_valid_q;
	logic [7:0] result_q;
	logic [3:0] flags_q;

	logic       advance;
	logic       take;
	logic [7:0] alu_result;
	aaf_state_t alu_next;

	// Advance the input stage into the result register when the result
	// register is empty or its content is taken this cycle.
	assign advance = valid_s1 & (~out_valid_q | response.ready);
	// Take a new operation whenever the input stage empties or moves on.
	assign take    = operation.valid & operation.ready;

	assign operation.ready = ~valid_s1 | advance;

	aaf_alu u_alu (
		.item   (item_s1),
		.cur    (state_q),
		.result (alu_result),
		.nxt    (alu_next)
	);

	// Control state and architectural registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
			state_q     <= '0;
		end else begin
			if (take) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
			if (advance) begin
				out_valid_q <= 1'b1;
				// commit the state in order with the result
				state_q     <= alu_next;
			end else if (response.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers: hold while stalled.
	always_ff @(posedge clk) begin
		if (take) begin
			item_s1.func           <= operation.func;
			item_s1.operand        <= operation.operand;
			item_s1.to_accumulator <= operation.to_accumulator;
			item_s1.bit_pos        <= operation.bit_pos;
		end
		if (advance) begin
			result_q <= alu_result;
			flags_q  <= alu_next.flags;
		end
	end

	assign response.valid  = out_valid_q;
	assign response.result = result_q;
	assign response.flags  = flags_q;

endmodule

/* sim/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench - self-checking bench for the accumulator ALU with flags
// Sends operations over the valid/ready operation channel, predicts each
// response from a behavioral model of the accumulator and the Z/N/C flags,
// and compares every response transfer in order. Both channel sides idle at
// random, with stretches of full-rate streaming in between.
// ----------------------------------------------------------------------------
module testbench;
	import aaf_pkg::*;

	// codes left undefined by the block; it must pass them through untouched
	localparam logic [3:0] FUNC_UNUSED_E = 4'd14;
	localparam logic [3:0] FUNC_UNUSED_F = 4'd15;

	// end-of-run settle time
	localparam int SETTLE_CYCLES  = 12;
	// cycles without any transfer before the run is declared hung
	localparam int WATCHDOG_LIMIT = 2000;

	typedef struct packed {
		logic [7:0] result;
		logic [3:0] flags;
	} alu_resp_t;

	logic clk;
	logic arst_n;

	aaf_in_if  op_if ();
	aaf_out_if rsp_if ();

	accumulator_alu_with_flags DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.operation(op_if),
		.response (rsp_if)
	);

	// behavioral copy of the architectural state
	logic [7:0] model_acc;
	logic [3:0] model_flags;

	// responses predicted at operation transfer, oldest first
	alu_resp_t pending_results[$];

	int error_count;
	int idle_cycles;
	int rx_stall_left;
	// chance in percent that a transfer is preceded by a gap (sender) or stall
	// (receiver); zero gives full-rate streaming
	int tx_gap_pct;
	int rx_stall_pct;

	// ------------------------------------------------------------------------
	// Clock: 20 ns period
	// ------------------------------------------------------------------------
	initial clk = 1'b0;
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// ------------------------------------------------------------------------
	// Gap length: mostly none, sometimes short, rarely long
	// ------------------------------------------------------------------------
	function automatic int pick_gap(input int pct);
		if ($urandom_range(0, 99) >= pct)
			return 0;
		if ($urandom_range(0, 9) == 0)
			return $urandom_range(8, 30);
		return $urandom_range(1, 3);
	endfunction

	// ------------------------------------------------------------------------
	// Predictor: execute one operation on the model state and return the
	// response the block should produce for it
	// ------------------------------------------------------------------------
	function automatic alu_resp_t alu_execute(input aaf_item_t op);
		alu_resp_t  rsp;
		logic [8:0] sum;
		logic [8:0] subtrahend;
		logic [8:0] diff;
		logic [7:0] val;
		logic [7:0] res;
		logic [3:0] fl;
		logic       cin;

		cin = model_flags[FLAG_C];
		val = op.to_accumulator ? model_acc : op.operand;
		res = model_acc;
		fl  = model_flags;

		case (op.func)
			FUNC_ADD, FUNC_ADC: begin
				sum = {1'b0, model_acc} + {1'b0, op.operand}
					+ ((op.func == FUNC_ADC) ? {8'd0, cin} : 9'd0);
				fl = '0;
				fl[FLAG_Z] = (sum[7:0] == 8'd0);
				fl[FLAG_C] = sum[8];
				model_acc = sum[7:0];
				res = model_acc;
			end
			FUNC_SUB, FUNC_SBC, FUNC_CP: begin
				// borrow in may push the subtrahend to 256
				subtrahend = {1'b0, op.operand}
					+ ((op.func == FUNC_SBC) ? {8'd0, cin} : 9'd0);
				diff = {1'b0, model_acc} - subtrahend;
				fl = '0;
				fl[FLAG_Z] = (diff[7:0] == 8'd0);
				fl[FLAG_N] = 1'b1;
				fl[FLAG_C] = (subtrahend > {1'b0, model_acc});
				if (op.func != FUNC_CP)
					model_acc = diff[7:0];
				res = model_acc;
			end
			FUNC_AND, FUNC_OR, FUNC_XOR: begin
				if (op.func == FUNC_AND)
					res = model_acc & op.operand;
				else if (op.func == FUNC_OR)
					res = model_acc | op.operand;
				else
					res = model_acc ^ op.operand;
				fl = '0;
				fl[FLAG_Z] = (res == 8'd0);
				model_acc = res;
			end
			FUNC_INC, FUNC_DEC, FUNC_RL, FUNC_RLC: begin
				fl = '0;
				case (op.func)
					FUNC_INC: res = val + 8'd1;
					FUNC_DEC: res = val - 8'd1;
					FUNC_RL: begin
						res = {val[6:0], cin};
						fl[FLAG_C] = val[7];
					end
					default: begin
						res = {val[6:0], val[7]};
						fl[FLAG_C] = val[7];
					end
				endcase
				fl[FLAG_Z] = (res == 8'd0);
				if (op.to_accumulator)
					model_acc = res;
			end
			FUNC_BIT: begin
				fl = '0;
				fl[FLAG_Z] = ~op.operand[op.bit_pos];
			end
			FUNC_LDA: begin
				model_acc = op.operand;
				res = model_acc;
			end
			default: ;
		endcase

		model_flags = fl;
		rsp.result = res;
		rsp.flags  = fl;
		return rsp;
	endfunction

	function automatic aaf_item_t mk_op(input logic [3:0] func, input logic [7:0] operand,
		input logic to_acc, input logic [2:0] pos);
		aaf_item_t op;
		op.func           = func;
		op.operand        = operand;
		op.to_accumulator = to_acc;
		op.bit_pos        = pos;
		return op;
	endfunction

	function automatic aaf_item_t random_op();
		logic [3:0] func;
		logic [7:0] operand;
		int         r;

		r = $urandom_range(0, 99);
		if (r < 2)
			func = FUNC_UNUSED_E;
		else if (r < 4)
			func = FUNC_UNUSED_F;
		else
			func = 4'($urandom_range(FUNC_ADD, FUNC_LDA));
		// lean on the byte extremes, where carry and zero flip
		case ($urandom_range(0, 7))
			0: operand = 8'h00;
			1: operand = 8'hff;
			2: operand = 8'h80;
			3: operand = 8'h7f;
			default: operand = 8'($urandom);
		endcase
		return mk_op(func, operand, 1'($urandom), 3'($urandom));
	endfunction

	// ------------------------------------------------------------------------
	// Sender: one operation transfer. Valid stays high straight into the next
	// operation when no gap is drawn, so back-to-back transfers get exercised.
	// ------------------------------------------------------------------------
	task automatic send_op(input aaf_item_t op);
		int gap;
		gap = pick_gap(tx_gap_pct);
		if (gap > 0) begin
			op_if.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		op_if.valid          <= 1'b1;
		op_if.func           <= op.func;
		op_if.operand        <= op.operand;
		op_if.to_accumulator <= op.to_accumulator;
		op_if.bit_pos        <= op.bit_pos;
		do @(posedge clk); while (!op_if.ready);
		// transfer taken at this edge: predict in acceptance order
		pending_results.push_back(alu_execute(op));
	endtask

	// Hold the sender off until every predicted response has come back.
	task automatic wait_for_drain();
		op_if.valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
	endtask

	// ------------------------------------------------------------------------
	// Response checker and receiver stall generator
	// ------------------------------------------------------------------------
	always @(posedge clk) begin
		alu_resp_t want;
		int        n;
		if (arst_n && rsp_if.valid && rsp_if.ready) begin
			if (pending_results.size() == 0) begin
				$error("unexpected response: result %02h flags %01h",
					rsp_if.result, rsp_if.flags);
				error_count++;
			end else begin
				want = pending_results.pop_front();
				if (rsp_if.result !== want.result) begin
					$error("result: expected %02h actual %02h", want.result, rsp_if.result);
					error_count++;
				end
				if (rsp_if.flags !== want.flags) begin
					$error("flags: expected %01h actual %01h", want.flags, rsp_if.flags);
					error_count++;
				end
			end
		end
		// drop ready for a stall, or hold it high
		if (rx_stall_left > 0) begin
			rx_stall_left--;
			rsp_if.ready <= 1'b0;
		end else begin
			n = pick_gap(rx_stall_pct);
			if (n > 0) begin
				rx_stall_left = n - 1;
				rsp_if.ready <= 1'b0;
			end else begin
				rsp_if.ready <= 1'b1;
			end
		end
	end

	// ------------------------------------------------------------------------
	// Watchdog: any transfer on either side counts as progress
	// ------------------------------------------------------------------------
	always @(posedge clk) begin
		if (arst_n) begin
			if ((op_if.valid && op_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
				idle_cycles = 0;
			end else begin
				idle_cycles++;
				if (idle_cycles >= WATCHDOG_LIMIT) begin
					$display("tb: failure");
					$finish;
				end
			end
		end
	end

	// ------------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------------

	// Every operation at the byte extremes, the unused codes, and fields that
	// the operation should ignore.
	task automatic test_directed();
		tx_gap_pct   = 0;
		rx_stall_pct = 0;
		send_op(mk_op(FUNC_LDA, 8'hff, 1'b0, 3'd0));
		send_op(mk_op(FUNC_ADD, 8'h01, 1'b1, 3'd7));    // wraps to zero, carry out
		send_op(mk_op(FUNC_ADC, 8'hff, 1'b0, 3'd0));    // carry in from last add
		send_op(mk_op(FUNC_ADC, 8'h00, 1'b0, 3'd0));
		send_op(mk_op(FUNC_SUB, 8'h00, 1'b0, 3'd0));
		send_op(mk_op(FUNC_SUB, 8'hff, 1'b1, 3'd5));    // borrow
		send_op(mk_op(FUNC_SBC, 8'hff, 1'b0, 3'd0));    // borrow in makes 256
		send_op(mk_op(FUNC_CP, 8'h00, 1'b0, 3'd0));
		send_op(mk_op(FUNC_CP, 8'hff, 1'b0, 3'd0));
		send_op(mk_op(FUNC_LDA, 8'h80, 1'b0, 3'd0));
		send_op(mk_op(FUNC_AND, 8'h00, 1'b0, 3'd0));
		send_op(mk_op(FUNC_OR, 8'hff, 1'b1, 3'd3));
		send_op(mk_op(FUNC_XOR, 8'hff, 1'b0, 3'd0));    // back to zero
		send_op(mk_op(FUNC_INC, 8'hff, 1'b0, 3'd0));    // operand wraps, acc kept
		send_op(mk_op(FUNC_INC, 8'h00, 1'b1, 3'd0));
		send_op(mk_op(FUNC_DEC, 8'h00, 1'b0, 3'd0));
		send_op(mk_op(FUNC_DEC, 8'h00, 1'b1, 3'd0));    // acc 1 -> 0
		send_op(mk_op(FUNC_RL, 8'h80, 1'b0, 3'd0));     // zero result, carry set
		send_op(mk_op(FUNC_RL, 8'h00, 1'b1, 3'd0));     // old carry shifts in
		send_op(mk_op(FUNC_RLC, 8'h80, 1'b0, 3'd0));    // bit 7 wraps to bit 0
		send_op(mk_op(FUNC_RLC, 8'hff, 1'b1, 3'd0));
		send_op(mk_op(FUNC_BIT, 8'h80, 1'b1, 3'd7));
		send_op(mk_op(FUNC_BIT, 8'hfe, 1'b0, 3'd0));
		send_op(mk_op(FUNC_UNUSED_E, 8'hff, 1'b1, 3'd7));
		send_op(mk_op(FUNC_UNUSED_F, 8'h00, 1'b0, 3'd0));
	endtask

	// Pause the sender until the pipeline is empty, then restart, a few times.
	task automatic test_pause_and_drain();
		int k;
		tx_gap_pct   = 20;
		rx_stall_pct = 20;
		for (k = 0; k < 5; k++) begin
			repeat ($urandom_range(1, 6)) send_op(random_op());
			wait_for_drain();
		end
	endtask

	// Full-rate streaming with neither side idling.
	task automatic test_streaming();
		tx_gap_pct   = 0;
		rx_stall_pct = 0;
		repeat (250) send_op(random_op());
	endtask

	// Random traffic in phases with varying idle pressure on both sides.
	task automatic test_random_traffic();
		int phase;
		for (phase = 0; phase < 15; phase++) begin
			tx_gap_pct   = $urandom_range(0, 60);
			rx_stall_pct = $urandom_range(0, 60);
			repeat (100) send_op(random_op());
			if (phase % 4 == 3)
				wait_for_drain();
		end
	endtask

	// ------------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------------
	initial begin
		error_count   = 0;
		idle_cycles   = 0;
		rx_stall_left = 0;
		tx_gap_pct    = 0;
		rx_stall_pct  = 0;
		model_acc     = '0;
		model_flags   = '0;
		arst_n        = 1'b0;
		op_if.valid          <= 1'b0;
		op_if.func           <= FUNC_ADD;
		op_if.operand        <= '0;
		op_if.to_accumulator <= 1'b0;
		op_if.bit_pos        <= '0;

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		test_directed();
		test_pause_and_drain();
		test_streaming();
		test_random_traffic();

		// let the last responses drain, then watch for strays
		wait_for_drain();
		repeat (SETTLE_CYCLES) @(posedge clk);

		if (error_count == 0 && pending_results.size() == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule

/* files.f */
sv/aaf_pkg.sv
sv/aaf_in_if.sv
sv/aaf_out_if.sv
sv/aaf_alu.sv
sv/accumulator_alu_with_flags.sv
sim/testbench.sv
